FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the neighbor-count block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GNC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define GNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gnc_pkg.sv
// Types and constants of the 3x3 neighbor-count block.
package gnc_pkg;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 6;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 6'd32;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd1;

    // Stream payload widths
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 8;
    localparam int COUNT_W     = 4;

    // Three-row history of one column: bit 0 newest row, bit 2 oldest
    typedef logic [2:0] t_word;

    // One report request handed to the count unit
    typedef struct packed {
        t_word      left;
        t_word      center;
        t_word      right;
        logic       left_ok;
        logic       right_ok;
        logic       pos;
        logic [2:0] rows_valid;
        logic       row_end;
        logic       fin;
    } t_req;

    // One finished result
    typedef struct packed {
        logic               marked;
        logic [COUNT_W-1:0] count;
        logic               row_end;
        logic               last;
    } t_result;

endpackage

FILE: rtl/gnc_cell.sv
// One column cell of the line-buffer chain: holds a three-row column history.
module gnc_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  gnc_pkg::t_word i_word,
    output gnc_pkg::t_word o_word
);

    gnc_pkg::t_word r_word;

    // Take the neighbor's word on every accepted cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

FILE: rtl/gnc_count.sv
// Neighbor count of one reported cell from three adjacent column words.
module gnc_count (
    input  gnc_pkg::t_req    i_req,
    output gnc_pkg::t_result o_res
);

    function automatic logic [1:0] pop3(input gnc_pkg::t_word v);
        pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

    gnc_pkg::t_word w_rows;
    gnc_pkg::t_word w_self;
    gnc_pkg::t_word w_l;
    gnc_pkg::t_word w_r;
    gnc_pkg::t_word w_c;

    // Mask the rows inside the grid, drop the reported cell itself
    always_comb begin
        w_rows = i_req.pos ? i_req.rows_valid : (i_req.rows_valid & 3'b011);
        w_self = w_rows & ~(i_req.pos ? 3'b010 : 3'b001);
        w_l    = i_req.left_ok  ? (i_req.left  & w_rows) : 3'b000;
        w_r    = i_req.right_ok ? (i_req.right & w_rows) : 3'b000;
        w_c    = i_req.center & w_self;
    end

    // Add the three column counts
    always_comb begin
        o_res.count   = {2'b00, pop3(w_l)} + {2'b00, pop3(w_r)} + {2'b00, pop3(w_c)};
        o_res.marked  = i_req.pos ? i_req.center[1] : i_req.center[0];
        o_res.row_end = i_req.row_end;
        o_res.last    = i_req.fin;
    end

endmodule

FILE: rtl/grid_neighbor_count_3x3.sv
// Top level of the streamed 3x3 neighbor-count block.
// Takes a binary grid in row-major order, one cell per transfer, and reports
// each cell's marked bit with the count (0..8) of marked cells among its
// in-grid neighbors. A row is reported while the row below it arrives;
// the final row is reported as it arrives, and its last cell carries tlast.
// Writing grid_width or grid_height restarts the frame at row 0, column 0.
// Flow: a cell that releases results holds the input until the last of them is
// loaded for output. The first row of a taller frame releases none.
// On a middle row every cell after column 0 releases one, and the row end
// releases two. On the final row every cell after column 0 releases one for
// the row above plus one of its own, and the final cell releases up to four.
// The single output register drains one result per cycle while the output is
// not stalled; a stalled output holds the input for as long as the stall lasts.
// The line buffer is a chain of MAX_WIDTH column cells that shifts by one on
// each accepted cell; the word that falls out at column grid_width-1 is the
// same column one row earlier.
`include "assert_macros.svh"

module grid_neighbor_count_3x3 #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [gnc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gnc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [gnc_pkg::TDATA_IN_W-1:0]     i_s_tdata,   // [0] cell_marked
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [gnc_pkg::TDATA_OUT_W-1:0]    o_m_tdata,   // [0] out_marked, [4:1] neighbor_count
    output logic                               o_m_tuser,   // [0] row_end
    output logic                               o_m_tlast    // last result of the frame
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [gnc_pkg::WIDTH_W-1:0] MAX_W = gnc_pkg::WIDTH_W'(MAX_WIDTH);

    // Result slots of one item, in delivery order
    localparam int SLOT_UP_PREV   = 0;
    localparam int SLOT_LAST_PREV = 1;
    localparam int SLOT_UP_END    = 2;
    localparam int SLOT_LAST_END  = 3;
    localparam int NUM_SLOTS      = 4;

    typedef struct packed {
        logic       prev_left_ok;
        logic       end_left_ok;
        logic [2:0] v_up;
        logic [2:0] v_last;
    } t_ctx;

    logic [gnc_pkg::WIDTH_W-1:0]  r_width;
    logic [gnc_pkg::HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]             r_col;
    logic [gnc_pkg::HEIGHT_W-1:0] r_row;
    logic [NUM_SLOTS-1:0]         r_pend;
    logic [NUM_SLOTS-1:0]         n_pend;
    logic                         r_out_valid;
    logic                         n_out_valid;
    gnc_pkg::t_result             r_out;
    t_ctx                         r_ctx;
    t_ctx                         n_ctx;

    logic [gnc_pkg::WIDTH_W-1:0]  w_last6;
    logic [COL_W-1:0]             w_last;
    logic [gnc_pkg::HEIGHT_W-1:0] h_last;
    logic                         s_acc;
    logic                         col_end;
    logic                         last_row;
    logic                         c_ge1;
    logic                         r_ge1;
    logic [NUM_SLOTS-1:0]         new_mask;
    logic [NUM_SLOTS-1:0]         pend_first;
    logic [NUM_SLOTS-1:0]         pend_rem;
    logic                         load;

    gnc_pkg::t_word               w_chain [MAX_WIDTH];
    gnc_pkg::t_word               w_tap;
    gnc_pkg::t_word               n_head;
    gnc_pkg::t_word               w_n0;
    gnc_pkg::t_word               w_n1;
    gnc_pkg::t_word               w_n2;
    gnc_pkg::t_req                w_req;
    gnc_pkg::t_result             w_res;

    // Effective width and height
    always_comb begin
        if (r_width == '0) begin
            w_last6 = '0;
        end else if (r_width > MAX_W) begin
            w_last6 = MAX_W - 6'd1;
        end else begin
            w_last6 = r_width - 6'd1;
        end
        h_last = (r_height == '0) ? '0 : r_height - 16'd1;
    end
    assign w_last = w_last6[COL_W-1:0];

    // Position flags of the current cell
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign col_end  = (r_col == w_last);
    assign last_row = (r_row >= h_last);
    assign c_ge1    = (r_col != '0);
    assign r_ge1    = (r_row != '0);

    // Line-buffer chain: new word enters cell 0, the tap is the same column
    assign w_tap  = w_chain[w_last];
    assign n_head = {w_tap[1:0], i_s_tdata[0]};

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            gnc_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (s_acc),
                .i_word (n_head),
                .o_word (w_chain[k])
            );
        end else begin : g_body
            gnc_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (s_acc),
                .i_word (w_chain[k-1]),
                .o_word (w_chain[k])
            );
        end
    end

    // Words of the current column and the two before it
    assign w_n0 = w_chain[0];
    if (MAX_WIDTH > 1) begin : g_n1
        assign w_n1 = w_chain[1];
    end else begin : g_n1_none
        assign w_n1 = '0;
    end
    if (MAX_WIDTH > 2) begin : g_n2
        assign w_n2 = w_chain[2];
    end else begin : g_n2_none
        assign w_n2 = '0;
    end

    // Results released by the accepted cell
    always_comb begin
        new_mask                 = '0;
        new_mask[SLOT_UP_PREV]   = c_ge1 && r_ge1;
        new_mask[SLOT_LAST_PREV] = c_ge1 && last_row;
        new_mask[SLOT_UP_END]    = col_end && r_ge1;
        new_mask[SLOT_LAST_END]  = col_end && last_row;
        n_ctx.prev_left_ok       = (r_col > COL_W'(1));
        n_ctx.end_left_ok        = c_ge1;
        n_ctx.v_up               = {(r_row > 16'd1), 2'b11};
        n_ctx.v_last             = {1'b0, r_ge1, 1'b1};
    end

    // Pick the oldest pending slot and build its request
    assign pend_first = r_pend & (~r_pend + NUM_SLOTS'(1));

    always_comb begin
        w_req = '0;
        priority if (pend_first[SLOT_UP_PREV] || pend_first[SLOT_LAST_PREV]) begin
            w_req.left       = w_n2;
            w_req.center     = w_n1;
            w_req.right      = w_n0;
            w_req.left_ok    = r_ctx.prev_left_ok;
            w_req.right_ok   = 1'b1;
            w_req.pos        = pend_first[SLOT_UP_PREV];
            w_req.rows_valid = pend_first[SLOT_UP_PREV] ? r_ctx.v_up : r_ctx.v_last;
        end else begin
            w_req.left       = w_n1;
            w_req.center     = w_n0;
            w_req.left_ok    = r_ctx.end_left_ok;
            w_req.pos        = pend_first[SLOT_UP_END];
            w_req.rows_valid = pend_first[SLOT_UP_END] ? r_ctx.v_up : r_ctx.v_last;
            w_req.row_end    = 1'b1;
            w_req.fin        = pend_first[SLOT_LAST_END];
        end
    end

    gnc_count u_count (
        .i_req (w_req),
        .o_res (w_res)
    );

    // Drain one result per cycle into the output register while the output is not stalled
    always_comb begin
        load        = (r_pend != '0) && (!r_out_valid || i_m_tready);
        pend_rem    = load ? (r_pend & ~pend_first) : r_pend;
        n_pend      = s_acc ? new_mask : pend_rem;
        n_out_valid = load ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
    end

    assign o_s_tready = (pend_rem == '0);

    // Control state: configuration, position, pending slots, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= gnc_pkg::RESET_WIDTH;
            r_height    <= gnc_pkg::RESET_HEIGHT;
            r_col       <= '0;
            r_row       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gnc_pkg::REG_GRID_WIDTH: begin
                        r_width <= i_cfg_data[gnc_pkg::WIDTH_W-1:0];
                    end
                    gnc_pkg::REG_GRID_HEIGHT: begin
                        r_height <= i_cfg_data[gnc_pkg::HEIGHT_W-1:0];
                    end
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (s_acc) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: result register and per-item context
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= w_res;
        end
        if (s_acc) begin
            r_ctx <= n_ctx;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(gnc_pkg::TDATA_OUT_W - gnc_pkg::COUNT_W - 1){1'b0}},
                         r_out.count, r_out.marked};
    assign o_m_tuser  = r_out.row_end;
    assign o_m_tlast  = r_out.last;

    // Checks
    `GNC_ASSERT_ALWAYS(a_last_ends_row, o_m_tvalid && o_m_tlast |-> o_m_tuser, "last result not at row end")
    `GNC_ASSERT_ALWAYS(a_count_range, o_m_tvalid |-> (o_m_tdata[4:1] <= 4'd8), "neighbor count above eight")
    `GNC_ASSERT_ALWAYS(a_col_in_row, r_col <= w_last, "column position beyond row width")
    `GNC_ASSERT_NEXT(a_frame_wrap, s_acc && col_end && last_row, (r_row == '0) && (r_col == '0), "frame did not restart")

endmodule
